### hdl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and codes for the two-stack double-ended queue.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int SIDE_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    localparam logic [2:0] K_NONE     = 3'd0;
    localparam logic [2:0] K_WR_FRONT = 3'd1;
    localparam logic [2:0] K_WR_BACK  = 3'd2;
    localparam logic [2:0] K_RD_FRONT = 3'd3;
    localparam logic [2:0] K_RD_BACK  = 3'd4;

    typedef struct packed {
        logic [2:0]          kind;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

### hdl/tsd_ram.sv
// ----------------------------------------------------------------------------
// tsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tsd_ram #(
    parameter int WIDTH = tsd_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = tsd_pkg::SIDE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tsd_fifo.sv
// ----------------------------------------------------------------------------
// tsd_fifo
// Small register queue used between the front and back parts and for results.
// ----------------------------------------------------------------------------
module tsd_fifo #(
    parameter int WIDTH = tsd_pkg::CTL_W,
    parameter int DEPTH = tsd_pkg::CMDQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### hdl/tsd_front.sv
// ----------------------------------------------------------------------------
// tsd_front
// Accepts operations, keeps the stack counts and turns each operation into
// one memory command with its precomputed status and size.
// ----------------------------------------------------------------------------
module tsd_front #(
    parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
    parameter int DATA_WIDTH = tsd_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [tsd_pkg::OP_W-1:0]      i_op,
    input  logic [tsd_pkg::VALUE_W-1:0]   i_value,
    input  logic [tsd_pkg::POS_W-1:0]     i_position,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output tsd_pkg::t_ctl                 o_ctl,
    output logic [$clog2(SIDE_DEPTH)-1:0] o_addr,
    output logic [DATA_WIDTH-1:0]         o_wdata
);

    localparam int AW = $clog2(SIDE_DEPTH);
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int TW = (CW + 1 > tsd_pkg::COUNT_W) ? CW + 1 : tsd_pkg::COUNT_W;

    logic [CW-1:0] r_front_cnt, n_front_cnt;
    logic [CW-1:0] r_back_cnt, n_back_cnt;
    logic [TW-1:0] w_pos;
    logic [TW-1:0] w_front;
    logic [TW-1:0] w_total;
    logic [TW-1:0] w_new_total;
    logic          w_accept;

    assign w_accept = i_push && !i_q_full;
    assign w_pos    = TW'(i_position);
    assign w_front  = TW'(r_front_cnt);
    assign w_total  = TW'(r_front_cnt) + TW'(r_back_cnt);

    always_comb begin
        n_front_cnt  = r_front_cnt;
        n_back_cnt   = r_back_cnt;
        o_ctl.kind   = tsd_pkg::K_NONE;
        o_ctl.status = tsd_pkg::ST_OK;
        o_addr       = '0;
        case (i_op)
            tsd_pkg::OP_PUSH_FRONT: begin
                if (r_front_cnt == CW'(SIDE_DEPTH)) begin
                    o_ctl.status = tsd_pkg::ST_FULL;
                end else begin
                    o_ctl.kind  = tsd_pkg::K_WR_FRONT;
                    o_addr      = r_front_cnt[AW-1:0];
                    n_front_cnt = r_front_cnt + CW'(1);
                end
            end
            tsd_pkg::OP_PUSH_BACK: begin
                if (r_back_cnt == CW'(SIDE_DEPTH)) begin
                    o_ctl.status = tsd_pkg::ST_FULL;
                end else begin
                    o_ctl.kind = tsd_pkg::K_WR_BACK;
                    o_addr     = r_back_cnt[AW-1:0];
                    n_back_cnt = r_back_cnt + CW'(1);
                end
            end
            tsd_pkg::OP_READ_INDEX: begin
                if (w_pos >= w_total) begin
                    o_ctl.status = tsd_pkg::ST_RANGE;
                end else if (w_pos < w_front) begin
                    o_ctl.kind = tsd_pkg::K_RD_FRONT;
                    o_addr     = AW'(w_front - w_pos - TW'(1));
                end else begin
                    o_ctl.kind = tsd_pkg::K_RD_BACK;
                    o_addr     = AW'(w_pos - w_front);
                end
            end
            tsd_pkg::OP_READ_FRONT: begin
                if (w_total == '0) begin
                    o_ctl.status = tsd_pkg::ST_EMPTY;
                end else if (r_front_cnt == '0) begin
                    o_ctl.kind = tsd_pkg::K_RD_BACK;
                end else begin
                    o_ctl.kind = tsd_pkg::K_RD_FRONT;
                    o_addr     = AW'(r_front_cnt - CW'(1));
                end
            end
            tsd_pkg::OP_READ_BACK: begin
                if (w_total == '0) begin
                    o_ctl.status = tsd_pkg::ST_EMPTY;
                end else if (r_back_cnt == '0) begin
                    o_ctl.kind = tsd_pkg::K_RD_FRONT;
                end else begin
                    o_ctl.kind = tsd_pkg::K_RD_BACK;
                    o_addr     = AW'(r_back_cnt - CW'(1));
                end
            end
            default: begin
                o_ctl.kind = tsd_pkg::K_NONE;
            end
        endcase
        w_new_total    = TW'(n_front_cnt) + TW'(n_back_cnt);
        o_ctl.count    = w_new_total[tsd_pkg::COUNT_W-1:0];
        o_ctl.is_empty = (w_new_total == '0);
    end

    assign o_wdata        = DATA_WIDTH'(64'(i_value));
    assign o_q_push       = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cnt <= '0;
            r_back_cnt  <= '0;
        end else if (w_accept) begin
            r_front_cnt <= n_front_cnt;
            r_back_cnt  <= n_back_cnt;
        end
    end

endmodule

### hdl/tsd_back.sv
// ----------------------------------------------------------------------------
// tsd_back
// Carries out queued memory commands on the two stack stores and collects
// the finished results in a small output queue.
// ----------------------------------------------------------------------------
module tsd_back #(
    parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
    parameter int DATA_WIDTH = tsd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_q_empty,
    input  logic [tsd_pkg::CTL_W+$clog2(SIDE_DEPTH)+DATA_WIDTH-1:0] i_q_data,
    output logic                                                  o_q_pop,
    input  logic                                                  i_pop,
    output logic                                                  o_empty,
    output logic [tsd_pkg::DATA_W-1:0]                            o_data,
    output logic [tsd_pkg::STATUS_W-1:0]                          o_status,
    output logic [tsd_pkg::COUNT_W-1:0]                           o_count,
    output logic                                                  o_is_empty
);

    localparam int AW   = $clog2(SIDE_DEPTH);
    localparam int OD   = tsd_pkg::OUTQ_DEPTH;
    localparam int OCW  = $clog2(OD + 1);
    localparam int PW   = $clog2(OD + 2);
    localparam int OUTW = tsd_pkg::CTL_W + tsd_pkg::DATA_W;

    tsd_pkg::t_ctl          w_cmd_ctl;
    logic [AW-1:0]          w_cmd_addr;
    logic [DATA_WIDTH-1:0]  w_cmd_wdata;
    logic                   w_issue;
    logic [PW-1:0]          w_pending;
    logic [OCW-1:0]         w_out_count;
    logic                   w_out_full;
    logic                   w_out_pop;

    logic                   r_s1_valid;
    tsd_pkg::t_ctl          r_s1_ctl;

    logic [DATA_WIDTH-1:0]  w_front_rdata;
    logic [DATA_WIDTH-1:0]  w_back_rdata;
    logic [DATA_WIDTH-1:0]  w_sel_rdata;
    logic [63:0]            w_sel_ext;
    logic [OUTW-1:0]        w_out_in;
    logic [OUTW-1:0]        w_out_data;
    tsd_pkg::t_ctl          w_out_ctl;

    assign {w_cmd_ctl, w_cmd_addr, w_cmd_wdata} = i_q_data;

    assign w_out_pop = i_pop && !o_empty;
    assign w_pending = PW'(w_out_count) + PW'(r_s1_valid);
    assign w_issue   = !i_q_empty
                    && (w_pending < (PW'(OD) + PW'(w_out_pop)));
    assign o_q_pop   = w_issue;

    tsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_front_store (
        .i_clk   (i_clk),
        .i_we    (w_issue && (w_cmd_ctl.kind == tsd_pkg::K_WR_FRONT)),
        .i_waddr (w_cmd_addr),
        .i_wdata (w_cmd_wdata),
        .i_raddr (w_cmd_addr),
        .o_rdata (w_front_rdata)
    );

    tsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_back_store (
        .i_clk   (i_clk),
        .i_we    (w_issue && (w_cmd_ctl.kind == tsd_pkg::K_WR_BACK)),
        .i_waddr (w_cmd_addr),
        .i_wdata (w_cmd_wdata),
        .i_raddr (w_cmd_addr),
        .o_rdata (w_back_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_ctl <= w_cmd_ctl;
        end
    end

    always_comb begin
        case (r_s1_ctl.kind)
            tsd_pkg::K_RD_FRONT: w_sel_rdata = w_front_rdata;
            tsd_pkg::K_RD_BACK:  w_sel_rdata = w_back_rdata;
            default:             w_sel_rdata = '0;
        endcase
    end

    assign w_sel_ext = 64'(w_sel_rdata);
    assign w_out_in  = {r_s1_ctl, w_sel_ext[tsd_pkg::DATA_W-1:0]};

    tsd_fifo #(
        .WIDTH (OUTW),
        .DEPTH (OD)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (w_out_in),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign {w_out_ctl, o_data} = w_out_data;
    assign o_status   = w_out_ctl.status;
    assign o_count    = w_out_ctl.count;
    assign o_is_empty = w_out_ctl.is_empty && !w_out_full | w_out_ctl.is_empty;

endmodule

### hdl/two_stack_deque_unit.sv
// ----------------------------------------------------------------------------
// two_stack_deque_unit
// Double-ended queue without removal, held as a front stack and a back stack.
// ----------------------------------------------------------------------------
// A result reaches the result ports through the command queue, the registered
// store read and the result queue. Throughput: one operation per cycle while
// neither queue is stalled, set by the one stack store access that each operation
// needs and the one command issued from the command queue each cycle.
// Reset clears both stack counts and empties the command and result queues;
// the stack stores are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module two_stack_deque_unit #(
    parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
    parameter int DATA_WIDTH = tsd_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [tsd_pkg::OP_W-1:0]      i_op,
    input  logic [tsd_pkg::VALUE_W-1:0]   i_value,
    input  logic [tsd_pkg::POS_W-1:0]     i_position,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [tsd_pkg::DATA_W-1:0]    o_data,
    output logic [tsd_pkg::STATUS_W-1:0]  o_status,
    output logic [tsd_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty
);

    localparam int AW   = $clog2(SIDE_DEPTH);
    localparam int CMDW = tsd_pkg::CTL_W + AW + DATA_WIDTH;

    logic                  w_q_push;
    logic                  w_q_pop;
    logic                  w_q_empty;
    tsd_pkg::t_ctl         w_ctl;
    logic [AW-1:0]         w_addr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [CMDW-1:0]       w_q_in;
    logic [CMDW-1:0]       w_q_out;

    tsd_front #(
        .SIDE_DEPTH (SIDE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_position (i_position),
        .i_q_full   (o_full),
        .o_q_push   (w_q_push),
        .o_ctl      (w_ctl),
        .o_addr     (w_addr),
        .o_wdata    (w_wdata)
    );

    assign w_q_in = {w_ctl, w_addr, w_wdata};

    tsd_fifo #(
        .WIDTH (CMDW),
        .DEPTH (tsd_pkg::CMDQ_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (o_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty),
        .o_count ()
    );

    tsd_back #(
        .SIDE_DEPTH (SIDE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_out),
        .o_q_pop    (w_q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

endmodule

### hdl/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks on the result stream of the deque, bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_push,
    input logic                          o_full,
    input logic [tsd_pkg::OP_W-1:0]      i_op,
    input logic [tsd_pkg::VALUE_W-1:0]   i_value,
    input logic [tsd_pkg::POS_W-1:0]     i_position,
    input logic                          i_pop,
    input logic                          o_empty,
    input logic [tsd_pkg::DATA_W-1:0]    o_data,
    input logic [tsd_pkg::STATUS_W-1:0]  o_status,
    input logic [tsd_pkg::COUNT_W-1:0]   o_count,
    input logic                          o_is_empty
);

    // A reset always leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_flag_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with the size");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status != tsd_pkg::ST_OK)) |-> (o_data == '0))
        else $error("failed transaction carries non-zero data");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status == tsd_pkg::ST_EMPTY)) |-> (o_is_empty && (o_count == '0)))
        else $error("queue-empty status reported on a non-empty deque");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_data) && $stable(o_status)
                                  && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind two_stack_deque_unit tsd_checker u_tsd_checker (.*);
